/* rtl/pressure_temp_compensation_core_assert.svh */
// assertion macros for the compensation core
// expects clk and rst_n in the scope where a macro is used
`ifndef PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define PTC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* rtl/ptc_pkg.sv */
// shared constants and helpers for the compensation core
// no dependencies
package ptc_pkg;

    localparam logic [31:0] TEMP_OFFSET_FINE = 32'd64000;
    localparam logic [31:0] PRESS_BASE       = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE      = 32'd3125;
    localparam logic [31:0] HALF_RANGE       = 32'h8000_0000;
    localparam logic [31:0] DIV_BIAS         = 32'd32768;
    localparam logic [31:0] ROUND_TEMP       = 32'd128;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_CALIB       = 3'd0;
    localparam logic [2:0] REG_PRESS_CALIB_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_CALIB_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_CALIB_LAST = 3'd3;

    // pipeline shape
    localparam int DIV_STEPS  = 32;
    localparam int PRE_STAGES = 11;
    localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS + 3;

    typedef logic [31:0] word_t;

    // arithmetic right shift of a 32-bit word
    function automatic word_t asr32(input word_t x, input int unsigned n);
        return word_t'($signed(x) >>> n);
    endfunction

    // low 32 bits of a product
    function automatic word_t mul32(input word_t a, input word_t b);
        return a * b;
    endfunction

    // sign-extended 16-bit coefficient
    function automatic word_t sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* rtl/pressure_temp_compensation_core.sv */
// Compensation core: throughput one reading pair per cycle; busy is always low.
// The datapath is a 46-stage pipeline, 32 stages of which are a one-bit-per-stage divider.
// Reset clears the valid bits and the calibration registers; results cannot be stalled.
// Depends on ptc_pkg and pressure_temp_compensation_core_assert.svh.
`include "pressure_temp_compensation_core_assert.svh"

module pressure_temp_compensation_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        raw_pressure,
    input  logic [19:0]        raw_temperature,
    output logic               done,
    output logic signed [31:0] temperature_centi,
    output logic [31:0]        pressure_pascal,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int NS = ptc_pkg::NUM_STAGES;
    localparam int ND = ptc_pkg::DIV_STEPS;

    // calibration registers
    logic [47:0] temp_calib_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;

    ptc_pkg::word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_CALIB:       temp_calib_reg <= cfg_data[47:0];
                ptc_pkg::REG_PRESS_CALIB_LOW:  press_lo_reg   <= cfg_data;
                ptc_pkg::REG_PRESS_CALIB_HIGH: press_hi_reg   <= cfg_data;
                ptc_pkg::REG_PRESS_CALIB_LAST: press_last_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // coefficient slices
    assign t1 = {16'd0, temp_calib_reg[15:0]};
    assign t2 = ptc_pkg::sext16(temp_calib_reg[31:16]);
    assign t3 = ptc_pkg::sext16(temp_calib_reg[47:32]);
    assign p1 = {16'd0, press_lo_reg[15:0]};
    assign p2 = ptc_pkg::sext16(press_lo_reg[31:16]);
    assign p3 = ptc_pkg::sext16(press_lo_reg[47:32]);
    assign p4 = ptc_pkg::sext16(press_lo_reg[63:48]);
    assign p5 = ptc_pkg::sext16(press_hi_reg[15:0]);
    assign p6 = ptc_pkg::sext16(press_hi_reg[31:16]);
    assign p7 = ptc_pkg::sext16(press_hi_reg[47:32]);
    assign p8 = ptc_pkg::sext16(press_hi_reg[63:48]);
    assign p9 = ptc_pkg::sext16(press_last_reg);

    // valid bits travel alongside the data
    logic [NS-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-2:0], start && !busy};
    end

    // stage a: input capture
    logic [19:0] a_adcp_reg, a_adct_reg;

    always_ff @(posedge clk)
    begin
        a_adcp_reg <= raw_pressure;
        a_adct_reg <= raw_temperature;
    end

    // stage b: first temperature products
    logic [19:0]    b_adcp_reg;
    ptc_pkg::word_t b_ma_reg, b_md_reg;
    ptc_pkg::word_t b_x, b_d;

    assign b_x = ptc_pkg::word_t'(a_adct_reg >> 3) - (t1 << 1);
    assign b_d = ptc_pkg::word_t'(a_adct_reg >> 4) - t1;

    always_ff @(posedge clk)
    begin
        b_adcp_reg <= a_adcp_reg;
        b_ma_reg   <= ptc_pkg::mul32(b_x, t2);
        b_md_reg   <= ptc_pkg::mul32(b_d, b_d);
    end

    // stage c: square term times t3
    logic [19:0]    c_adcp_reg;
    ptc_pkg::word_t c_a_reg, c_e_reg;

    always_ff @(posedge clk)
    begin
        c_adcp_reg <= b_adcp_reg;
        c_a_reg    <= ptc_pkg::asr32(b_ma_reg, 11);
        c_e_reg    <= ptc_pkg::mul32(ptc_pkg::asr32(b_md_reg, 12), t3);
    end

    // stage d: fine temperature
    logic [19:0]    d_adcp_reg;
    ptc_pkg::word_t d_fine_reg;

    always_ff @(posedge clk)
    begin
        d_adcp_reg <= c_adcp_reg;
        d_fine_reg <= c_a_reg + ptc_pkg::asr32(c_e_reg, 14);
    end

    // stage e: temperature output word and pressure offsets
    logic [19:0]    e_adcp_reg;
    ptc_pkg::word_t e_temp_reg, e_v1_reg, e_q_reg, e_v1;

    assign e_v1 = ptc_pkg::asr32(d_fine_reg, 1) - ptc_pkg::TEMP_OFFSET_FINE;

    always_ff @(posedge clk)
    begin
        e_adcp_reg <= d_adcp_reg;
        e_temp_reg <= ptc_pkg::asr32((d_fine_reg << 2) + d_fine_reg + ptc_pkg::ROUND_TEMP, 8);
        e_v1_reg   <= e_v1;
        e_q_reg    <= ptc_pkg::asr32(e_v1, 2);
    end

    // stage f: first pressure products
    logic [19:0]    f_adcp_reg;
    ptc_pkg::word_t f_temp_reg, f_qq_reg, f_m5_reg, f_m2_reg;

    always_ff @(posedge clk)
    begin
        f_adcp_reg <= e_adcp_reg;
        f_temp_reg <= e_temp_reg;
        f_qq_reg   <= ptc_pkg::mul32(e_q_reg, e_q_reg);
        f_m5_reg   <= ptc_pkg::mul32(e_v1_reg, p5);
        f_m2_reg   <= ptc_pkg::mul32(p2, e_v1_reg);
    end

    // stage g: square term products
    logic [19:0]    g_adcp_reg;
    ptc_pkg::word_t g_temp_reg, g_m6_reg, g_m3_reg, g_m5_reg, g_m2_reg;

    always_ff @(posedge clk)
    begin
        g_adcp_reg <= f_adcp_reg;
        g_temp_reg <= f_temp_reg;
        g_m6_reg   <= ptc_pkg::mul32(ptc_pkg::asr32(f_qq_reg, 11), p6);
        g_m3_reg   <= ptc_pkg::mul32(p3, ptc_pkg::asr32(f_qq_reg, 13));
        g_m5_reg   <= f_m5_reg;
        g_m2_reg   <= f_m2_reg;
    end

    // stage h: sums for v2 and v1
    logic [19:0]    h_adcp_reg;
    ptc_pkg::word_t h_temp_reg, h_v2_reg, h_v1_reg;

    always_ff @(posedge clk)
    begin
        h_adcp_reg <= g_adcp_reg;
        h_temp_reg <= g_temp_reg;
        h_v2_reg   <= ptc_pkg::asr32(g_m6_reg + (g_m5_reg << 1), 2) + (p4 << 16);
        h_v1_reg   <= ptc_pkg::asr32(ptc_pkg::asr32(g_m3_reg, 3)
                                     + ptc_pkg::asr32(g_m2_reg, 1), 18);
    end

    // stage i: divisor product and raw pressure term
    ptc_pkg::word_t i_temp_reg, i_dv_reg, i_pp_reg;

    always_ff @(posedge clk)
    begin
        i_temp_reg <= h_temp_reg;
        i_dv_reg   <= ptc_pkg::mul32(ptc_pkg::DIV_BIAS + h_v1_reg, p1);
        i_pp_reg   <= (ptc_pkg::PRESS_BASE - ptc_pkg::word_t'(h_adcp_reg))
                      - ptc_pkg::asr32(h_v2_reg, 12);
    end

    // stage j: scaled pressure and final divisor
    ptc_pkg::word_t j_temp_reg, j_p_reg, j_div_reg;

    always_ff @(posedge clk)
    begin
        j_temp_reg <= i_temp_reg;
        j_p_reg    <= ptc_pkg::mul32(i_pp_reg, ptc_pkg::PRESS_SCALE);
        j_div_reg  <= ptc_pkg::asr32(i_dv_reg, 15);
    end

    // restoring divider, one quotient bit per stage; entry 0 is the dividend selection
    ptc_pkg::word_t dv_rem_reg  [ND+1];
    ptc_pkg::word_t dv_num_reg  [ND+1];
    ptc_pkg::word_t dv_quo_reg  [ND+1];
    ptc_pkg::word_t dv_div_reg  [ND+1];
    ptc_pkg::word_t dv_temp_reg [ND+1];
    logic           dv_dbl_reg  [ND+1];
    logic [32:0]    dv_trial    [ND];
    logic           dv_fits     [ND];

    // trial subtraction for every divider stage
    always_comb
    begin
        for (int s = 0; s < ND; s++)
        begin
            dv_trial[s] = {dv_rem_reg[s], dv_num_reg[s][31]};
            dv_fits[s]  = dv_trial[s] >= {1'b0, dv_div_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]  <= '0;
        dv_quo_reg[0]  <= '0;
        dv_div_reg[0]  <= j_div_reg;
        dv_temp_reg[0] <= j_temp_reg;
        dv_dbl_reg[0]  <= !(j_p_reg < ptc_pkg::HALF_RANGE);
        dv_num_reg[0]  <= (j_p_reg < ptc_pkg::HALF_RANGE) ? (j_p_reg << 1) : j_p_reg;
        for (int s = 0; s < ND; s++)
        begin
            dv_rem_reg[s+1]  <= dv_fits[s]
                                ? ptc_pkg::word_t'(dv_trial[s] - {1'b0, dv_div_reg[s]})
                                : dv_trial[s][31:0];
            dv_num_reg[s+1]  <= dv_num_reg[s] << 1;
            dv_quo_reg[s+1]  <= {dv_quo_reg[s][30:0], dv_fits[s]};
            dv_div_reg[s+1]  <= dv_div_reg[s];
            dv_temp_reg[s+1] <= dv_temp_reg[s];
            dv_dbl_reg[s+1]  <= dv_dbl_reg[s];
        end
    end

    // stage l: quotient fix-up and correction products
    ptc_pkg::word_t l_p, l_ps;
    ptc_pkg::word_t l_temp_reg, l_p_reg, l_pp3_reg, l_m8_reg;
    logic           l_zero_reg;

    assign l_p  = dv_dbl_reg[ND] ? (dv_quo_reg[ND] << 1) : dv_quo_reg[ND];
    assign l_ps = l_p >> 3;

    always_ff @(posedge clk)
    begin
        l_temp_reg <= dv_temp_reg[ND];
        l_zero_reg <= (dv_div_reg[ND] == '0);
        l_p_reg    <= l_p;
        l_pp3_reg  <= ptc_pkg::mul32(l_ps, l_ps);
        l_m8_reg   <= ptc_pkg::mul32(l_p >> 2, p8);
    end

    // stage m: p9 term
    ptc_pkg::word_t m_temp_reg, m_p_reg, m_m9_reg, m_m8_reg;
    logic           m_zero_reg;

    always_ff @(posedge clk)
    begin
        m_temp_reg <= l_temp_reg;
        m_zero_reg <= l_zero_reg;
        m_p_reg    <= l_p_reg;
        m_m8_reg   <= l_m8_reg;
        m_m9_reg   <= ptc_pkg::mul32(p9, l_pp3_reg >> 13);
    end

    // stage n: output word
    ptc_pkg::word_t n_temp_reg, n_press_reg, n_press_next;

    assign n_press_next = m_zero_reg ? '0
                        : m_p_reg + ptc_pkg::asr32(ptc_pkg::asr32(m_m9_reg, 12)
                                                   + ptc_pkg::asr32(m_m8_reg, 13) + p7, 4);

    always_ff @(posedge clk)
    begin
        n_temp_reg  <= m_temp_reg;
        n_press_reg <= n_press_next;
    end

    assign done              = vld_reg[NS-1];
    assign temperature_centi = $signed(n_temp_reg);
    assign pressure_pascal   = n_press_reg;

    // checks
    `PTC_ASSERT_DLY(a_latency, start && !busy, 46, done, "word did not emerge after 46 cycles")
    `PTC_ASSERT_NOW(a_rem_bound, vld_reg[NS-4] && (dv_div_reg[ND] != '0),
                    dv_rem_reg[ND] < dv_div_reg[ND], "divider remainder not below divisor")
    `PTC_ASSERT_NOW(a_no_spurious, done, $past(vld_reg[NS-2]), "done without a word in flight")

endmodule

/* verif/pressure_temp_compensation_core_tb.sv */
// testbench for the pressure and temperature compensation core
// depends on ptc_pkg and pressure_temp_compensation_core
`timescale 1ns / 100ps

module pressure_temp_compensation_core_tb;

    typedef struct packed {
        logic [19:0] press;
        logic [19:0] temp;
    } reading_t;

    typedef struct packed {
        logic [31:0] temp_c;
        logic [31:0] press_pa;
    } comp_t;

    localparam int LATENCY     = 46;
    localparam int WATCH_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic        done;
    logic signed [31:0] temperature_centi;
    logic [31:0] pressure_pascal;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // local copy of the calibration registers
    logic [47:0] cal_t;
    logic [63:0] cal_pl;
    logic [63:0] cal_ph;
    logic [15:0] cal_p9;

    reading_t pending_q[$];
    comp_t    expected_q[$];
    int       gap_left;
    int       idle_cycles;
    int       errors = 0;
    bit       feeding;

    pressure_temp_compensation_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .raw_pressure      (raw_pressure),
        .raw_temperature   (raw_temperature),
        .done              (done),
        .temperature_centi (temperature_centi),
        .pressure_pascal   (pressure_pascal),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // integer compensation of one reading pair
    function automatic comp_t compensate(input reading_t r);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, v1, v2, q, p, ap, at;
        comp_t c;
        ap = {12'd0, r.press};
        at = {12'd0, r.temp};
        t1 = {16'd0, cal_t[15:0]};
        t2 = sx(cal_t[31:16]);
        t3 = sx(cal_t[47:32]);
        p1 = {16'd0, cal_pl[15:0]};
        p2 = sx(cal_pl[31:16]);
        p3 = sx(cal_pl[47:32]);
        p4 = sx(cal_pl[63:48]);
        p5 = sx(cal_ph[15:0]);
        p6 = sx(cal_ph[31:16]);
        p7 = sx(cal_ph[47:32]);
        p8 = sx(cal_ph[63:48]);
        p9 = sx(cal_p9);
        a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        c.temp_c = sra(fine * 32'd5 + 32'd128, 8);
        v1 = sra(fine, 1) - 32'd64000;
        q = sra(v1, 2);
        v2 = sra(q * q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
        v1 = sra((32'd32768 + v1) * p1, 15);
        if (v1 == 32'd0) begin
            c.press_pa = 32'd0;
        end
        else begin
            p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000)
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = sra((p >> 2) * p8, 13);
            c.press_pa = p + sra(v1 + v2 + p7, 4);
        end
        return c;
    endfunction

    // driver: one word per start, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start           <= 1'b0;
            raw_pressure    <= '0;
            raw_temperature <= '0;
            gap_left        <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_q.push_back(compensate({raw_pressure, raw_temperature}));
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (feeding && pending_q.size() > 0)
            begin
                {raw_pressure, raw_temperature} <= pending_q.pop_front();
                start    <= 1'b1;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        comp_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected, got %h %h", $time,
                         temperature_centi, pressure_pascal);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (temperature_centi !== e.temp_c)
                begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             $signed(e.temp_c), temperature_centi);
                    errors++;
                end
                if (pressure_pascal !== e.press_pa)
                begin
                    $display("%0t: pressure expected %0d actual %0d", $time,
                             e.press_pa, pressure_pascal);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ptc_pkg::REG_TEMP_CALIB:       cal_t  = val[47:0];
            ptc_pkg::REG_PRESS_CALIB_LOW:  cal_pl = val;
            ptc_pkg::REG_PRESS_CALIB_HIGH: cal_ph = val;
            ptc_pkg::REG_PRESS_CALIB_LAST: cal_p9 = val[15:0];
            default: ;
        endcase
    endtask

    // let the queued words run through and drain
    task automatic run_batch();
        feeding = 1'b1;
        wait (pending_q.size() == 0 && !start);
        feeding = 1'b0;
        @(posedge clk);
        wait (expected_q.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // typical sensor calibration with random spread
    task automatic typical_cal();
        write_reg(ptc_pkg::REG_TEMP_CALIB, {16'(-1000 + $urandom_range(0, 2000)),
                                            16'(26000 + $urandom_range(0, 2000)),
                                            16'(27000 + $urandom_range(0, 2000))});
        write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, {16'(2800 + $urandom_range(0, 200)),
                                                 16'(3000 + $urandom_range(0, 2000)),
                                                 16'(-10700 + $urandom_range(0, 200)),
                                                 16'(36000 + $urandom_range(0, 4000))});
        write_reg(ptc_pkg::REG_PRESS_CALIB_HIGH, {16'(-12000 + $urandom_range(0, 200)),
                                                  16'(15000 + $urandom_range(0, 200)),
                                                  16'(-7),
                                                  16'(140 + $urandom_range(0, 20))});
        write_reg(ptc_pkg::REG_PRESS_CALIB_LAST, 64'(16'(4900 + $urandom_range(0, 200))));
    endtask

    function automatic reading_t rnd_reading(input bit typical);
        reading_t r;
        if (typical)
        begin
            r.press = 20'(300000 + $urandom_range(0, 300000));
            r.temp  = 20'(450000 + $urandom_range(0, 200000));
        end
        else
        begin
            r.press = 20'($urandom());
            r.temp  = 20'($urandom());
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_t = '0;
        cal_pl = '0;
        cal_ph = '0;
        cal_p9 = '0;
        feeding = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: zero divisor everywhere
        pending_q.push_back({20'd0, 20'd0});
        pending_q.push_back({20'hFFFFF, 20'hFFFFF});
        run_batch();

        // directed extremes under a typical calibration
        typical_cal();
        pending_q.push_back({20'd0, 20'd0});
        pending_q.push_back({20'hFFFFF, 20'hFFFFF});
        pending_q.push_back({20'd0, 20'hFFFFF});
        pending_q.push_back({20'hFFFFF, 20'd0});
        pending_q.push_back({20'd415148, 20'd519888});
        pending_q.push_back({20'h55555, 20'hAAAAA});
        pending_q.push_back({20'hAAAAA, 20'h55555});
        run_batch();

        // extreme calibrations: all ones, sign bits or maximum values, then a zero low pressure word
        write_reg(ptc_pkg::REG_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ptc_pkg::REG_PRESS_CALIB_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ptc_pkg::REG_PRESS_CALIB_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++)
            pending_q.push_back(rnd_reading(1'b0));
        run_batch();
        write_reg(ptc_pkg::REG_TEMP_CALIB, 64'h0000_8000_8000_7FFF);
        write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, 64'h8000_8000_8000_7FFF);
        write_reg(ptc_pkg::REG_PRESS_CALIB_HIGH, 64'h8000_8000_8000_8000);
        write_reg(ptc_pkg::REG_PRESS_CALIB_LAST, 64'h0000_0000_0000_8000);
        for (int i = 0; i < 4; i++)
            pending_q.push_back(rnd_reading(1'b0));
        run_batch();
        write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, 64'h0);
        pending_q.push_back(rnd_reading(1'b1));
        run_batch();

        // random phases: mostly plausible calibrations, some raw noise
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph % 3 == 2)
            begin
                write_reg(ptc_pkg::REG_TEMP_CALIB, rnd64());
                write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, rnd64());
                write_reg(ptc_pkg::REG_PRESS_CALIB_HIGH, rnd64());
                write_reg(ptc_pkg::REG_PRESS_CALIB_LAST, rnd64());
            end
            else
                typical_cal();
            for (int i = 0; i < 200; i++)
                pending_q.push_back(rnd_reading($urandom_range(0, 3) != 0));
            run_batch();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ptc_pkg.sv
rtl/pressure_temp_compensation_core.sv
verif/pressure_temp_compensation_core_tb.sv
